// ===== design/mbps_pkg.sv =====
package mbps_pkg;

   // Longest pattern the window supports; the window holds as many bytes.
   localparam int PATTERN_BYTES = 16;
   localparam int IDX_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

   localparam int BYTE_W = 8;
   localparam int COUNT_W = 32;
   localparam int LEN_W = 5;
   localparam int CARE_W = 16;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_INDEX_W = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_CARE_BITS    = 2'd2,
      CSR_PATTERN_LEN  = 2'd3
   } csr_index_type;

   typedef logic [PATTERN_BYTES-1:0][BYTE_W-1:0] window_type;

   // Settings as the matcher uses them, length already clamped to 1..PATTERN_BYTES.
   typedef struct packed {
      logic [2*CSR_DATA_W-1:0] pattern;
      logic [CARE_W-1:0]       care;
      logic [LEN_W-1:0]        length;
   } scan_cfg_type;

endpackage

// ===== design/mbps_csr.sv =====
module mbps_csr
   import mbps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output scan_cfg_type           cfg
);

   logic [CSR_DATA_W-1:0] pat_low_ff;
   logic [CSR_DATA_W-1:0] pat_high_ff;
   logic [CARE_W-1:0]     care_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [LEN_W-1:0]      len_used;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         care_ff     <= '1;
         len_ff      <= LEN_W'(1);
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_write_data;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_write_data;
            CSR_CARE_BITS:    care_ff     <= csr_write_data[CARE_W-1:0];
            CSR_PATTERN_LEN:  len_ff      <= csr_write_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // A length of zero acts as one, and anything past the window acts as a full window.
   always_comb begin
      if (len_ff == '0) begin
         len_used = LEN_W'(1);
      end else if (len_ff > LEN_W'(PATTERN_BYTES)) begin
         len_used = LEN_W'(PATTERN_BYTES);
      end else begin
         len_used = len_ff;
      end
   end

   assign cfg.pattern = {pat_high_ff, pat_low_ff};
   assign cfg.care    = care_ff;
   assign cfg.length  = len_used;

endmodule

// ===== design/mbps_match.sv =====
module mbps_match
   import mbps_pkg::*;
(
   input  scan_cfg_type cfg,
   input  window_type   window,
   output logic         hit
);

   logic [LEN_W-1:0] tap [PATTERN_BYTES];
   logic [PATTERN_BYTES-1:0] byte_ok;

   // Pattern byte j lines up with the byte that arrived length-1-j beats ago.
   always_comb begin
      for (int j = 0; j < PATTERN_BYTES; j++) begin
         tap[j] = cfg.length - LEN_W'(1) - LEN_W'(j);
         if ((LEN_W'(j) < cfg.length) && cfg.care[j]) begin
            byte_ok[j] = (window[tap[j][IDX_W-1:0]] == cfg.pattern[BYTE_W*j +: BYTE_W]);
         end else begin
            byte_ok[j] = 1'b1;
         end
      end
   end

   assign hit = &byte_ok;

endmodule

// ===== design/masked_byte_pattern_scanner_core.sv =====
// Scans a buffer presented one byte per beat on the req_ channel and returns one
// rsp_ beat per buffer: the start offset of the first place where the configured
// masked pattern (1 to 16 bytes, cleared care bits are wildcards) matches, or
// found=0 with offset 0 at the last byte if nothing matched. Matches after the
// first in a buffer are ignored, and a buffer shorter than the pattern reports
// not found. The block takes one byte every clock unless stalled: a byte is
// registered in the input register on acceptance, compared there against the
// 16-byte window, and its result lands in the output register; rsp_ready low
// stalls the input only once the output register and the input register are
// both full. The offset counter saturates at 2**32-1. Write the csr_ registers
// only while no buffer is in flight.
module masked_byte_pattern_scanner_core
   import mbps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [BYTE_W-1:0]      req_data_byte,
   input  logic                   req_end_of_buffer,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_found,
   output logic [COUNT_W-1:0]     rsp_match_offset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   scan_cfg_type cfg;

   logic              s1_valid_ff;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_last_ff;
   logic              s1_fire;

   window_type        window_ff;
   window_type        window_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic              reported_ff;

   logic              window_hit;
   logic              match_hit;
   logic              emit;

   logic              rsp_valid_ff;
   logic              rsp_found_ff;
   logic [COUNT_W-1:0] rsp_offset_ff;

   mbps_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   mbps_match u_match (
      .cfg    (cfg),
      .window (window_in),
      .hit    (window_hit)
   );

   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_end_of_buffer;
      end
   end

   always_comb begin
      window_in[0] = s1_byte_ff;
      for (int k = 1; k < PATTERN_BYTES; k++) begin
         window_in[k] = window_ff[k-1];
      end
      count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);
   end

   assign match_hit = !reported_ff && (count_in >= COUNT_W'(cfg.length)) && window_hit;
   assign emit      = match_hit || (s1_last_ff && !reported_ff);

   // The buffer state returns to its reset value after the last byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= '0;
         count_ff    <= '0;
         reported_ff <= 1'b0;
      end else if (s1_fire) begin
         if (s1_last_ff) begin
            window_ff   <= '0;
            count_ff    <= '0;
            reported_ff <= 1'b0;
         end else begin
            window_ff   <= window_in;
            count_ff    <= count_in;
            reported_ff <= reported_ff || match_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && emit) begin
         rsp_found_ff  <= match_hit;
         rsp_offset_ff <= match_hit ? (count_in - COUNT_W'(cfg.length)) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff;

endmodule

// ===== design/mbps_checker.sv =====
module mbps_checker
   import mbps_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [BYTE_W-1:0]      req_data_byte,
   input logic                   req_end_of_buffer,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_found,
   input logic [COUNT_W-1:0]     rsp_match_offset,
   input logic                   csr_write_enable,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_write_data
);

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_match_offset))
      else $error("result beat changed while stalled");

   // A not-found result always carries a zero offset.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_offset == '0)
      else $error("not-found result with nonzero offset");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // With the output free, the input never stalls.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while the output register is empty");

endmodule

bind masked_byte_pattern_scanner_core mbps_checker u_mbps_checker (.*);

// ===== tb/scan_result_checker.sv =====
module scan_result_checker
   import mbps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [BYTE_W-1:0]      req_data_byte,
   input  logic                   req_end_of_buffer,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   rsp_found,
   input  logic [COUNT_W-1:0]     rsp_match_offset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                     error_count,
   output int                     pending,
   output int                     checked_count,
   output int                     hit_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               found;
      logic [COUNT_W-1:0] offset;
   } scan_hit_type;

   scan_hit_type expected_hits[$];

   // Shadow copy of the settings and of the per-buffer scan state.
   logic [2*CSR_DATA_W-1:0] pattern;
   logic [CARE_W-1:0]       care;
   logic [LEN_W-1:0]        raw_len;
   logic [BYTE_W-1:0]       window [PATTERN_BYTES];
   logic [COUNT_W-1:0]      seen;
   logic                    reported;

   initial begin
      error_count = 0;
      pending = 0;
      checked_count = 0;
      hit_count = 0;
   end

   function automatic int clamp_len(input logic [LEN_W-1:0] l);
      if (l == 0)
         return 1;
      if (l > PATTERN_BYTES)
         return PATTERN_BYTES;
      return int'(l);
   endfunction

   // Pattern byte j lines up with the window entry len-1-j, entry 0 being newest.
   function automatic logic window_hits(input int len);
      for (int j = 0; j < len; j++) begin
         if (care[j] && window[len-1-j] != pattern[8*j +: 8])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic clear_scan();
      for (int k = 0; k < PATTERN_BYTES; k++)
         window[k] = '0;
      seen = '0;
      reported = 1'b0;
   endtask

   task automatic advance_window(input logic [BYTE_W-1:0] b, input logic last);
      int len;
      scan_hit_type hit;
      len = clamp_len(raw_len);
      for (int k = PATTERN_BYTES - 1; k > 0; k--)
         window[k] = window[k-1];
      window[0] = b;
      if (seen != COUNT_MAX)
         seen = seen + 1'b1;
      if (!reported && seen >= len && window_hits(len)) begin
         hit.found = 1'b1;
         hit.offset = seen - COUNT_W'(len);
         expected_hits.push_back(hit);
         reported = 1'b1;
      end
      if (last) begin
         if (!reported) begin
            hit.found = 1'b0;
            hit.offset = '0;
            expected_hits.push_back(hit);
         end
         clear_scan();
      end
   endtask

   task automatic compare_hit();
      scan_hit_type want;
      if (expected_hits.size() == 0) begin
         $error("rsp beat with nothing expected: found %0d match_offset %0d",
                rsp_found, rsp_match_offset);
         error_count++;
      end else begin
         want = expected_hits.pop_front();
         checked_count++;
         if (want.found)
            hit_count++;
         if (rsp_found !== want.found) begin
            $error("found: expected %0d actual %0d", want.found, rsp_found);
            error_count++;
         end
         if (rsp_match_offset !== want.offset) begin
            $error("match_offset: expected %0d actual %0d", want.offset, rsp_match_offset);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pattern = '0;
         care = '1;
         raw_len = LEN_W'(1);
         clear_scan();
         expected_hits.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_PATTERN_LOW:  pattern[CSR_DATA_W-1:0] = csr_write_data;
               CSR_PATTERN_HIGH: pattern[2*CSR_DATA_W-1:CSR_DATA_W] = csr_write_data;
               CSR_CARE_BITS:    care = csr_write_data[CARE_W-1:0];
               CSR_PATTERN_LEN:  raw_len = csr_write_data[LEN_W-1:0];
               default: ;
            endcase
         end
         // A result beat can never belong to a byte accepted at the same edge.
         if (rsp_valid && rsp_ready)
            compare_hit();
         if (req_valid && req_ready)
            advance_window(req_data_byte, req_end_of_buffer);
      end
      pending = expected_hits.size();
   end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   import mbps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_BYTES = 1100;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [BYTE_W-1:0]      req_data_byte;
   logic                   req_end_of_buffer;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_found;
   logic [COUNT_W-1:0]     rsp_match_offset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   int error_count;
   int pending;
   int checked_count;
   int hit_count;

   int cycle_count = 0;
   int bytes_sent = 0;
   int buffers_sent = 0;
   int settings_used = 0;
   int stall_left = 0;
   int free_run = 0;

   // What was last written, so that the stimulus can plant the pattern.
   logic [2*CSR_DATA_W-1:0] cur_pattern;
   logic [CARE_W-1:0]       cur_care;
   int                      cur_len;
   bit                      narrow_bytes;
   bit                      steady;

   masked_byte_pattern_scanner_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_buffer(req_end_of_buffer),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   scan_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_buffer(req_end_of_buffer),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending          (pending),
      .checked_count    (checked_count),
      .hit_count        (hit_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 8);
      return $urandom_range(12, 40);
   endfunction

   // Result side back-pressure, with stall-free stretches in between.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (free_run > 0)
            free_run <= free_run - 1;
         else if ($urandom_range(0, 99) < 4)
            free_run <= $urandom_range(50, 300);
         else if ($urandom_range(0, 99) < 30)
            stall_left <= pick_gap();
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      int gap;
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_buffer <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      bytes_sent++;
      gap = 0;
      if (!steady && $urandom_range(0, 99) < 35)
         gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every expected beat has come back and the pipeline is empty.
   task automatic settle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_scan(input logic [CSR_DATA_W-1:0] lo,
                               input logic [CSR_DATA_W-1:0] hi,
                               input logic [CSR_DATA_W-1:0] care_word,
                               input logic [CSR_DATA_W-1:0] len_word);
      logic [LEN_W-1:0] l;
      csr_write_enable <= 1'b1;
      csr_index <= CSR_PATTERN_LOW;
      csr_write_data <= lo;
      @(posedge clock);
      csr_index <= CSR_PATTERN_HIGH;
      csr_write_data <= hi;
      @(posedge clock);
      csr_index <= CSR_CARE_BITS;
      csr_write_data <= care_word;
      @(posedge clock);
      csr_index <= CSR_PATTERN_LEN;
      csr_write_data <= len_word;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_pattern = {hi, lo};
      cur_care = care_word[CARE_W-1:0];
      l = len_word[LEN_W-1:0];
      cur_len = (l == 0) ? 1 : (l > PATTERN_BYTES) ? PATTERN_BYTES : int'(l);
      settings_used++;
   endtask

   function automatic logic [BYTE_W-1:0] pick_byte();
      if (narrow_bytes && $urandom_range(0, 99) < 70)
         return cur_pattern[8*$urandom_range(0, cur_len - 1) +: 8];
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   task automatic scan_buffer(input int n, input bit plant);
      logic [BYTE_W-1:0] bytes[$];
      int pos;
      for (int i = 0; i < n; i++)
         bytes.push_back(pick_byte());
      if (plant) begin
         // Usually the whole pattern fits; otherwise it may run off the end.
         if (n >= cur_len && $urandom_range(0, 99) < 80)
            pos = $urandom_range(0, n - cur_len);
         else
            pos = $urandom_range(0, n - 1);
         for (int j = 0; j < cur_len; j++) begin
            if (pos + j < n)
               bytes[pos+j] = cur_care[j] ? cur_pattern[8*j +: 8]
                                          : BYTE_W'($urandom_range(0, 255));
         end
      end
      steady = ($urandom_range(0, 9) < 2);
      for (int i = 0; i < n; i++)
         send_byte(bytes[i], i == n - 1);
      buffers_sent++;
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] lo, hi, care_word, len_word;
      logic [CARE_W-1:0] care;
      int phase;
      int n;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_end_of_buffer = 1'b0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_PATTERN_LOW;
      csr_write_data = '0;
      cur_pattern = '0;
      cur_care = '1;
      cur_len = 1;
      narrow_bytes = 1'b0;
      steady = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Settings out of reset: a single zero byte with every care bit set.
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      buffers_sent += 3;
      settle();

      // Full-length pattern that ends exactly on the last byte of the buffer.
      program_scan(64'h8040201008040201, 64'hFF7F3F1F0F070301, 64'h000000000000FFFF,
                   64'h0000000000000010);
      for (int j = 0; j < PATTERN_BYTES; j++)
         send_byte(cur_pattern[8*j +: 8], j == PATTERN_BYTES - 1);
      buffers_sent++;
      settle();

      // Length zero counts as one, and with no care bits the first byte matches.
      program_scan('1, '0, 64'hA5A5A5A5A5A50000, 64'hFFFFFFFFFFFFFFE0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hA5, 1'b1);
      buffers_sent++;
      settle();

      bytes_sent = 0;
      phase = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         case (phase % 6)
            0: len_word = CSR_DATA_W'(16);
            1: len_word = CSR_DATA_W'(1);
            2: len_word = CSR_DATA_W'($urandom_range(17, 31));
            3: len_word = '0;
            default: len_word = CSR_DATA_W'($urandom_range(2, 15));
         endcase
         len_word[CSR_DATA_W-1:LEN_W] = (CSR_DATA_W-LEN_W)'({$urandom, $urandom});
         case ($urandom_range(0, 3))
            0: begin lo = '1; hi = '1; end
            1: begin lo = '0; hi = '0; end
            default: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
         endcase
         case ($urandom_range(0, 3))
            0: care = '1;
            1: care = '0;
            2: care = CARE_W'($urandom);
            default: care = CARE_W'($urandom | $urandom);
         endcase
         care_word = {$urandom, $urandom};
         care_word[CARE_W-1:0] = care;
         program_scan(lo, hi, care_word, len_word);
         narrow_bytes = ($urandom_range(0, 2) != 0);

         repeat ($urandom_range(6, 12)) begin
            case ($urandom_range(0, 19))
               0: n = $urandom_range(100, 300);
               1, 2, 3: n = $urandom_range(25, 80);
               default: n = $urandom_range(1, 24);
            endcase
            scan_buffer(n, $urandom_range(0, 99) < 55);
         end
         settle();
         phase++;
      end

      repeat (8) @(posedge clock);
      $display("Scanned %0d random bytes plus the directed cases in %0d buffers over %0d settings.",
               bytes_sent, buffers_sent, settings_used);
      $display("Checked %0d result beats, %0d of them matches.", checked_count, hit_count);
      if (error_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
